// ----- hw/rtl/uarh_pkg.sv -----
// Shared types and constants for the UART register access host.
package uarh_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] HDR_START  = 8'hAA;
  localparam logic [7:0] HDR_WRITE  = 8'h00;
  localparam logic [7:0] HDR_READ   = 8'h01;
  localparam logic [7:0] HDR_STATUS = 8'hEE;
  localparam logic [7:0] HDR_DATA   = 8'hBB;

  localparam logic [7:0] ACK_OK_RESET = 8'h01;

  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_PAYLOAD = 2'd2;
  localparam logic [1:0] REQ_RX      = 2'd3;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_REJECTED  = 3'd1;
  localparam logic [2:0] EV_ACKED     = 3'd2;
  localparam logic [2:0] EV_STATUS    = 3'd3;
  localparam logic [2:0] EV_READ_BYTE = 3'd4;
  localparam logic [2:0] EV_EMPTY_RD  = 3'd5;
  localparam logic [2:0] EV_FRAMING   = 3'd6;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] event_res;
    logic [7:0] rx_byte;
    logic       last;
  } out_item_t;

  // Work handed from front to back: either a four-byte command frame
  // or one finished result.
  typedef struct packed {
    logic      frame;
    logic      wr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    out_item_t res;
  } job_t;

endpackage

// ----- hw/rtl/uarh_front.sv -----
// Front end: accepts items, tracks protocol state and emits jobs.
module uarh_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  uarh_pkg::in_item_t in_item,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  output logic             job_push,
  output uarh_pkg::job_t   job
);

  typedef enum logic [1:0] {
    PH_HDR0 = 2'd0,
    PH_HDR1 = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic [7:0] rx_rem_r, rx_rem_nxt;
  logic [7:0] tx_rem_r, tx_rem_nxt;
  logic [7:0] ack_ok_r;
  logic       fin;

  always_comb begin
    phase_nxt  = phase_r;
    busy_nxt   = busy_r;
    hdr_nxt    = hdr_r;
    rx_rem_nxt = rx_rem_r;
    tx_rem_nxt = tx_rem_r;
    job_push   = 1'b0;
    job        = '0;
    fin        = (rx_rem_r <= 8'd1);
    if (in_valid) begin
      case (in_item.req_type)
        uarh_pkg::REQ_READ, uarh_pkg::REQ_WRITE: begin
          job_push = 1'b1;
          if (busy_r) begin
            job.res.event_res = uarh_pkg::EV_REJECTED;
            job.res.last      = 1'b1;
          end else begin
            job.frame    = 1'b1;
            job.wr       = (in_item.req_type == uarh_pkg::REQ_WRITE);
            job.reg_addr = in_item.reg_addr;
            job.length   = in_item.length;
            busy_nxt     = 1'b1;
            phase_nxt    = PH_HDR0;
            tx_rem_nxt   = (in_item.req_type == uarh_pkg::REQ_WRITE) ? in_item.length : 8'd0;
          end
        end
        uarh_pkg::REQ_PAYLOAD: begin
          // drop payload that no write is waiting for
          if (tx_rem_r != 8'd0) begin
            tx_rem_nxt       = tx_rem_r - 8'd1;
            job_push         = 1'b1;
            job.res.tx_valid = 1'b1;
            job.res.tx_byte  = in_item.data_byte;
            job.res.last     = 1'b1;
          end
        end
        default: begin
          case (phase_r)
            PH_HDR1: begin
              if (hdr_r == uarh_pkg::HDR_STATUS) begin
                busy_nxt     = 1'b0;
                phase_nxt    = PH_HDR0;
                tx_rem_nxt   = 8'd0;
                job_push     = 1'b1;
                job.res.last = 1'b1;
                if (in_item.data_byte == ack_ok_r) begin
                  job.res.event_res = uarh_pkg::EV_ACKED;
                end else begin
                  job.res.event_res = uarh_pkg::EV_STATUS;
                  job.res.rx_byte   = in_item.data_byte;
                end
              end else if (hdr_r == uarh_pkg::HDR_DATA) begin
                if (in_item.data_byte == 8'd0) begin
                  rx_rem_nxt        = 8'd0;
                  busy_nxt          = 1'b0;
                  phase_nxt         = PH_HDR0;
                  tx_rem_nxt        = 8'd0;
                  job_push          = 1'b1;
                  job.res.event_res = uarh_pkg::EV_EMPTY_RD;
                  job.res.last      = 1'b1;
                end else begin
                  rx_rem_nxt = in_item.data_byte;
                  phase_nxt  = PH_DATA;
                end
              end else begin
                busy_nxt          = 1'b0;
                phase_nxt         = PH_HDR0;
                tx_rem_nxt        = 8'd0;
                job_push          = 1'b1;
                job.res.event_res = uarh_pkg::EV_FRAMING;
                job.res.last      = 1'b1;
              end
            end
            PH_DATA: begin
              rx_rem_nxt        = fin ? 8'd0 : rx_rem_r - 8'd1;
              job_push          = 1'b1;
              job.res.event_res = uarh_pkg::EV_READ_BYTE;
              job.res.rx_byte   = in_item.data_byte;
              job.res.last      = fin;
              if (fin) begin
                busy_nxt   = 1'b0;
                phase_nxt  = PH_HDR0;
                tx_rem_nxt = 8'd0;
              end
            end
            default: begin
              hdr_nxt   = in_item.data_byte;
              phase_nxt = PH_HDR1;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      busy_r   <= 1'b0;
      hdr_r    <= 8'd0;
      rx_rem_r <= 8'd0;
      tx_rem_r <= 8'd0;
      ack_ok_r <= uarh_pkg::ACK_OK_RESET;
    end else begin
      phase_r  <= phase_nxt;
      busy_r   <= busy_nxt;
      hdr_r    <= hdr_nxt;
      rx_rem_r <= rx_rem_nxt;
      tx_rem_r <= tx_rem_nxt;
      if (cfg_we) begin
        ack_ok_r <= cfg_wdata;
      end
    end
  end

endmodule

// ----- hw/rtl/uarh_queue.sv -----
// Job queue between front and back ends.
module uarh_queue #(
  parameter int unsigned DEPTH = uarh_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  uarh_pkg::job_t wr_job,
  input  logic           rd_en,
  output uarh_pkg::job_t rd_job,
  output logic           q_full,
  output logic           q_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  uarh_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign q_full  = (count_r == FULL_CNT);
  assign q_empty = (count_r == '0);
  assign rd_job  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/uarh_back.sv -----
// Back end: expands jobs into results and holds the output register.
module uarh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  uarh_pkg::job_t     head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output uarh_pkg::out_item_t out_item
);

  logic                valid_r;
  uarh_pkg::out_item_t out_r, res;
  logic [1:0]          step_r;
  logic                load;

  assign empty    = !valid_r;
  assign out_item = out_r;
  assign load     = (!valid_r || pop) && !q_empty;
  assign q_pop    = load && (!head.frame || step_r == 2'd3);

  always_comb begin
    res = head.res;
    if (head.frame) begin
      res          = '0;
      res.tx_valid = 1'b1;
      case (step_r)
        2'd0:    res.tx_byte = uarh_pkg::HDR_START;
        2'd1:    res.tx_byte = head.wr ? uarh_pkg::HDR_WRITE : uarh_pkg::HDR_READ;
        2'd2:    res.tx_byte = head.reg_addr;
        default: begin
          res.tx_byte = head.length;
          res.last    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        // advance through frame bytes, restart on the next job
        step_r  <= q_pop ? 2'd0 : step_r + 2'd1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/uart_register_access_host_top.sv -----
// Top level of the UART register access host: front end, job queue and back end.
// With queue and output idle, an accepted transaction is written into the job queue,
// then its first result goes from the queue head into the output register.
// One item per cycle is accepted while full is low; the back end emits one result
// per cycle while pop keeps up, so a command frame makes four results, others one.
// The job queue (QDEPTH entries) absorbs bursts; full rises when it fills.
// Synchronous active-low reset empties queue and output and returns to idle.
module uart_register_access_host_top #(
  parameter int unsigned QDEPTH = uarh_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  uarh_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output uarh_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  logic           job_push, q_pop, q_empty;
  uarh_pkg::job_t job, head;

  uarh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push && !full),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .job_push (job_push),
    .job      (job)
  );

  uarh_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job),
    .rd_en  (q_pop),
    .rd_job (head),
    .q_full (full),
    .q_empty(q_empty)
  );

  uarh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule

// ----- hw/rtl/uarh_checker.sv -----
// Port-level checks for the UART register access host.
module uarh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input uarh_pkg::in_item_t  in_item,
  input logic                empty,
  input logic                pop,
  input uarh_pkg::out_item_t out_item
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not clear after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("stalled result changed");

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && (in_item.req_type == uarh_pkg::REQ_READ ||
                      in_item.req_type == uarh_pkg::REQ_WRITE) |-> ##2 !empty)
    else $error("command transaction gave no result");

  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_item.last |->
      (out_item.tx_valid && out_item.event_res == uarh_pkg::EV_NONE) ||
      (!out_item.tx_valid && out_item.event_res == uarh_pkg::EV_READ_BYTE))
    else $error("unexpected result without last mark");

endmodule

bind uart_register_access_host_top uarh_checker u_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .push    (push),
  .full    (full),
  .in_item (in_item),
  .empty   (empty),
  .pop     (pop),
  .out_item(out_item)
);

// ----- dv/uart_register_access_host_top_test.sv -----
// Self-checking testbench for the UART register access host: directed table plus random traffic.
module uart_register_access_host_top_test;

  typedef enum logic [1:0] {PH_HEADER, PH_SECOND, PH_DATA} rx_phase_t;

  typedef struct {
    uarh_pkg::in_item_t item;
    bit                 typed;
    logic [2:0]         ev;
    logic [7:0]         rxb;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  uarh_pkg::in_item_t  in_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  uarh_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic [7:0]          cfg_wdata = 8'h00;

  // Predictor state
  logic [7:0] ack_code = uarh_pkg::ACK_OK_RESET;
  logic       host_busy = 1'b0;
  rx_phase_t  rx_phase = PH_HEADER;
  logic [7:0] rx_hdr = 8'h00;
  logic [7:0] rx_left = 8'h00;
  logic [7:0] tx_left = 8'h00;

  uarh_pkg::out_item_t expected_out[$];
  stim_row_t           dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned pop_mode = 0;
  int unsigned pop_mode_left = 0;
  int unsigned cyc = 0;

  uart_register_access_host_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic uarh_pkg::in_item_t mk_item(input logic [1:0] rq, input logic [7:0] ra,
                                                 input logic [7:0] ln, input logic [7:0] db);
    uarh_pkg::in_item_t it;
    it.req_type  = rq;
    it.reg_addr  = ra;
    it.length    = ln;
    it.data_byte = db;
    return it;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] rq, input logic [7:0] ra,
                                       input logic [7:0] ln, input logic [7:0] db,
                                       input bit typed = 1'b0,
                                       input logic [2:0] ev = uarh_pkg::EV_NONE,
                                       input logic [7:0] rxb = 8'h00);
    stim_row_t row;
    row.item  = mk_item(rq, ra, ln, db);
    row.typed = typed;
    row.ev    = ev;
    row.rxb   = rxb;
    return row;
  endfunction

  function automatic void enter_idle();
    host_busy = 1'b0;
    rx_phase  = PH_HEADER;
    tx_left   = 8'h00;
  endfunction

  // Work out the results of one accepted transaction and advance the state.
  function automatic void predict_host(input uarh_pkg::in_item_t it,
                                       ref uarh_pkg::out_item_t res[$]);
    uarh_pkg::out_item_t r;
    res.delete();
    r = '0;
    case (it.req_type)
      uarh_pkg::REQ_READ, uarh_pkg::REQ_WRITE: begin
        if (host_busy) begin
          r.event_res = uarh_pkg::EV_REJECTED;
          r.last = 1'b1;
          res.push_back(r);
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte = uarh_pkg::HDR_START;
          res.push_back(r);
          r.tx_byte = (it.req_type == uarh_pkg::REQ_READ) ? uarh_pkg::HDR_READ
                                                          : uarh_pkg::HDR_WRITE;
          res.push_back(r);
          r.tx_byte = it.reg_addr;
          res.push_back(r);
          r.tx_byte = it.length;
          r.last = 1'b1;
          res.push_back(r);
          host_busy = 1'b1;
          rx_phase = PH_HEADER;
          tx_left = (it.req_type == uarh_pkg::REQ_WRITE) ? it.length : 8'h00;
        end
      end
      uarh_pkg::REQ_PAYLOAD: begin
        if (tx_left != 8'h00) begin
          tx_left = tx_left - 8'h01;
          r.tx_valid = 1'b1;
          r.tx_byte = it.data_byte;
          r.last = 1'b1;
          res.push_back(r);
        end
      end
      default: begin
        if (rx_phase == PH_SECOND) begin
          if (rx_hdr == uarh_pkg::HDR_STATUS) begin
            enter_idle();
            r.last = 1'b1;
            if (it.data_byte == ack_code) begin
              r.event_res = uarh_pkg::EV_ACKED;
            end else begin
              r.event_res = uarh_pkg::EV_STATUS;
              r.rx_byte = it.data_byte;
            end
            res.push_back(r);
          end else if (rx_hdr == uarh_pkg::HDR_DATA) begin
            if (it.data_byte == 8'h00) begin
              rx_left = 8'h00;
              enter_idle();
              r.event_res = uarh_pkg::EV_EMPTY_RD;
              r.last = 1'b1;
              res.push_back(r);
            end else begin
              rx_left = it.data_byte;
              rx_phase = PH_DATA;
            end
          end else begin
            enter_idle();
            r.event_res = uarh_pkg::EV_FRAMING;
            r.last = 1'b1;
            res.push_back(r);
          end
        end else if (rx_phase == PH_DATA) begin
          r.event_res = uarh_pkg::EV_READ_BYTE;
          r.rx_byte = it.data_byte;
          r.last = (rx_left <= 8'h01);
          rx_left = r.last ? 8'h00 : rx_left - 8'h01;
          res.push_back(r);
          if (r.last) enter_idle();
        end else begin
          rx_hdr = it.data_byte;
          rx_phase = PH_SECOND;
        end
      end
    endcase
  endfunction

  // Present one transaction, honoring burst gaps, and record what it should produce.
  task automatic drive_item(input uarh_pkg::in_item_t it, input bit typed = 1'b0,
                            input logic [2:0] ev = uarh_pkg::EV_NONE,
                            input logic [7:0] rxb = 8'h00);
    uarh_pkg::out_item_t res[$];
    uarh_pkg::out_item_t r;
    int unsigned         gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_host(it, res);
    items_sent++;
    if (typed) begin
      r = '0;
      r.event_res = ev;
      r.rx_byte = rxb;
      r.last = 1'b1;
      res.delete();
      res.push_back(r);
    end
    foreach (res[i]) expected_out.push_back(res[i]);
  endtask

  task automatic rx_byte_in(input logic [7:0] db);
    drive_item(mk_item(uarh_pkg::REQ_RX, rnd8(), rnd8(), db));
  endtask

  task automatic status_reply();
    rx_byte_in(uarh_pkg::HDR_STATUS);
    rx_byte_in($urandom_range(0, 1) ? ack_code : rnd8());
  endtask

  task automatic run_read_txn();
    int unsigned n;
    logic [7:0]  hdr;
    drive_item(mk_item(uarh_pkg::REQ_READ, rnd8(), rnd8(), rnd8()));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if ($urandom_range(0, 7) == 0) n = 0;
        else if ($urandom_range(0, 15) == 0) n = $urandom_range(11, 40);
        else n = $urandom_range(1, 10);
        rx_byte_in(uarh_pkg::HDR_DATA);
        rx_byte_in(8'(n));
        repeat (n) rx_byte_in(rnd8());
      end
      6, 7: status_reply();
      8: begin
        hdr = rnd8();
        if (hdr == uarh_pkg::HDR_STATUS || hdr == uarh_pkg::HDR_DATA) hdr = hdr ^ 8'h01;
        rx_byte_in(hdr);
        rx_byte_in(rnd8());
      end
      default: begin
        // second command while the first is outstanding
        drive_item(mk_item(uarh_pkg::REQ_WRITE, rnd8(), rnd8(), rnd8()));
        status_reply();
      end
    endcase
  endtask

  task automatic run_write_txn();
    logic [7:0]  len;
    int unsigned k;
    len = ($urandom_range(0, 3) == 0) ? rnd8() : 8'($urandom_range(0, 6));
    drive_item(mk_item(uarh_pkg::REQ_WRITE, rnd8(), len, rnd8()));
    k = (len > 8'd8) ? 8 : int'(len);
    if ($urandom_range(0, 3) == 0) k = k + $urandom_range(1, 2);
    repeat (k) drive_item(mk_item(uarh_pkg::REQ_PAYLOAD, rnd8(), rnd8(), rnd8()));
    status_reply();
  endtask

  // Hold the sender until every expected result is back, then let the pipe empty.
  task automatic drain();
    push <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_ack_code(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ack_code = v;
  endtask

  // Result side: check each popped result, then pick the next pop.
  always @(posedge clk) begin : result_side
    uarh_pkg::out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_item));
        end else begin
          want = expected_out.pop_front();
          if (out_item.tx_valid !== want.tx_valid)
            report_mismatch($sformatf("tx_valid %b, want %b", out_item.tx_valid, want.tx_valid));
          if (out_item.tx_byte !== want.tx_byte)
            report_mismatch($sformatf("tx_byte %h, want %h", out_item.tx_byte, want.tx_byte));
          if (out_item.event_res !== want.event_res)
            report_mismatch($sformatf("event_res %0d, want %0d",
                                      out_item.event_res, want.event_res));
          if (out_item.rx_byte !== want.rx_byte)
            report_mismatch($sformatf("rx_byte %h, want %h", out_item.rx_byte, want.rx_byte));
          if (out_item.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_item.last, want.last));
        end
      end
      if (pop_mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(16, 80);
      end
      pop_mode_left--;
      cyc++;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (cyc % 4 == 0);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    #400000;
    $display("uart_register_access_host_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  phase_code[4];
    int unsigned phase_start;
    int unsigned pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle header parse, reset ack code, busy rejection, empty read
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,    8'h00, 8'h00, uarh_pkg::HDR_STATUS));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,    8'h00, 8'h00, 8'h01, 1'b1,
                              uarh_pkg::EV_ACKED));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_READ,  8'h00, 8'hFF, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1,
                              uarh_pkg::EV_REJECTED));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,    8'h00, 8'h00, uarh_pkg::HDR_DATA));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,    8'h00, 8'h00, 8'h00, 1'b1,
                              uarh_pkg::EV_EMPTY_RD));
    // write with payload, one payload too many, status error
    dir_rows.push_back(mk_row(uarh_pkg::REQ_WRITE,   8'hFF, 8'h02, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'hFF));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_PAYLOAD, 8'hFF, 8'hFF, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h33));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,      8'h00, 8'h00, uarh_pkg::HDR_STATUS));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,      8'h00, 8'h00, 8'hFF, 1'b1,
                              uarh_pkg::EV_STATUS, 8'hFF));
    // three-byte read
    dir_rows.push_back(mk_row(uarh_pkg::REQ_READ, 8'h12, 8'h03, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, uarh_pkg::HDR_DATA));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, 8'h03));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'hFF, 8'hFF, 8'hFF));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, 8'hA5));
    // bad header ends the write; later payload is dropped
    dir_rows.push_back(mk_row(uarh_pkg::REQ_WRITE,   8'h34, 8'h01, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,      8'h00, 8'h00, 8'h12));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,      8'h00, 8'h00, 8'h34, 1'b1,
                              uarh_pkg::EV_FRAMING));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h77));
    // a command restarts header parsing
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, uarh_pkg::HDR_STATUS));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_READ, 8'h56, 8'h01, 8'h00));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, uarh_pkg::HDR_DATA));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, 8'h01));
    dir_rows.push_back(mk_row(uarh_pkg::REQ_RX,   8'h00, 8'h00, 8'h5C));

    foreach (dir_rows[i])
      drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].ev, dir_rows[i].rxb);
    drain();

    phase_code[0] = 8'h00;
    phase_code[1] = 8'hFF;
    phase_code[2] = rnd8();
    phase_code[3] = uarh_pkg::HDR_STATUS;
    for (int p = 0; p < 4; p++) begin
      write_ack_code(phase_code[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < 108) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          run_read_txn();
        end else if (pick < 8) begin
          run_write_txn();
        end else begin
          repeat ($urandom_range(1, 4))
            drive_item(mk_item(2'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8()));
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("uart_register_access_host_top regression: pass");
    end else begin
      $display("uart_register_access_host_top regression: fail");
    end
    $finish;
  end

endmodule
